// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define RWFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RWFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// File: rtl/core/rwfs_pkg.sv
// types, constants and word functions of the rtcm word and frame synchroniser
package rwfs_pkg;

  localparam int STORE_DEPTH = 33;
  localparam int STORE_AW    = 6;
  localparam int STORE_W     = 25;

  localparam logic [31:0] PAR_MASK_0    = 32'hbb1f3480;
  localparam logic [31:0] PAR_MASK_1    = 32'h5d8f9a40;
  localparam logic [31:0] PAR_MASK_2    = 32'haec7cd00;
  localparam logic [31:0] PAR_MASK_3    = 32'h5763e680;
  localparam logic [31:0] PAR_MASK_4    = 32'h6bb1f340;
  localparam logic [31:0] PAR_MASK_5    = 32'h8b7a89c0;
  localparam logic [31:0] DATA_MASK     = 32'h3fffffc0;
  localparam logic [31:0] PREAMBLE_VAL  = 32'h19800000;
  localparam logic [31:0] PREAMBLE_MASK = 32'h3fc00000;

  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_WSYNCING = 3'd1;
  localparam logic [2:0] MODE_WSYNC    = 3'd2;
  localparam logic [2:0] MODE_FSYNCING = 3'd3;
  localparam logic [2:0] MODE_FULL     = 3'd4;

  localparam logic [1:0] REG_WORD_SYNC   = 2'd0;
  localparam logic [1:0] REG_FRAME_SYNC  = 2'd1;
  localparam logic [1:0] REG_PARITY_FAIL = 2'd2;

  typedef struct packed {
    logic [3:0] word_sync_needed;
    logic [2:0] frame_sync_needed;
    logic [3:0] parity_fail_limit;
  } cfg_t;

  typedef struct packed {
    logic [23:0] word_data;
    logic [5:0]  word_index;
    logic        word_good;
    logic [4:0]  frame_length;
    logic [2:0]  sequence_number;
    logic [2:0]  sync_state;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic        good;
    logic [31:0] word;
  } chk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT,
    ST_FILL,
    ST_WORD,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_HDR_WR
  } back_state_t;

  // parity test with d30 inversion; word is zero when parity fails
  function automatic chk_t check_word(input logic [31:0] w);
    logic [31:0] th;
    logic [5:0]  p;
    chk_t        r;
    th = w[30] ? (w ^ DATA_MASK) : w;
    p[5] = ^(th & PAR_MASK_0);
    p[4] = ^(th & PAR_MASK_1);
    p[3] = ^(th & PAR_MASK_2);
    p[2] = ^(th & PAR_MASK_3);
    p[1] = ^(th & PAR_MASK_4);
    p[0] = ^(th & PAR_MASK_5);
    r.good = (w != 32'd0) && (w[5:0] == p);
    r.word = r.good ? th : 32'd0;
    return r;
  endfunction

  function automatic logic [31:0] next_word(input logic [31:0] sh, input logic [5:0] res);
    return {sh[1:0], 30'd0} | {2'b00, res, 24'd0};
  endfunction

  function automatic logic [24:0] pack_word(input logic [31:0] w);
    return (w != 32'd0) ? {1'b1, w[29:6]} : 25'd0;
  endfunction

  function automatic logic is_preamble(input logic [31:0] w);
    return (w & PREAMBLE_MASK) == PREAMBLE_VAL;
  endfunction

endpackage

// File: rtl/core/rtcm_word_frame_synchronizer.sv
// top level of the rtcm word and frame synchroniser with apb register port
// a data byte waits in the input queue, then passes engine states idle and fill, and the
// word state when it completes a 30-bit word; in bit hunting one bit a cycle is shifted in
// by the hunt state; a completed frame then sends each word by a store read state and an
// output register state, held while m_tready is low; the input queue takes bytes until full
// synchronous reset clears sync state, counters and queues; the frame store is not cleared
module rtcm_word_frame_synchronizer import rwfs_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // word_data[23:0], word_index[29:24], frame_length[34:30],
                                 // sequence_number[37:35], sync_state[40:38], zero[47:41]
  output logic        m_tuser,   // word_good[0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic       cfg_we;
  logic       q_valid;
  logic [5:0] q_data;
  logic       q_pop;
  out_beat_t  beat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.word_sync_needed  <= 4'd6;
      cfg.frame_sync_needed <= 3'd3;
      cfg.parity_fail_limit <= 4'd10;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_WORD_SYNC:   cfg.word_sync_needed  <= pwdata[3:0];
        REG_FRAME_SYNC:  cfg.frame_sync_needed <= pwdata[2:0];
        REG_PARITY_FAIL: cfg.parity_fail_limit <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WORD_SYNC:   prdata = {28'd0, cfg.word_sync_needed};
      REG_FRAME_SYNC:  prdata = {29'd0, cfg.frame_sync_needed};
      REG_PARITY_FAIL: prdata = {28'd0, cfg.parity_fail_limit};
      default:         prdata = 32'd0;
    endcase
  end

  rwfs_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  rwfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_beat  (beat),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'd0, beat.sync_state, beat.sequence_number, beat.frame_length,
                    beat.word_index, beat.word_data};
  assign m_tuser = beat.word_good;
  assign m_tlast = beat.last;

endmodule

// File: rtl/core/rwfs_ram.sv
// generic single write port ram with registered read
module rwfs_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/rwfs_front.sv
// input beat filter, payload bit reversal and queue towards the sync engine
`include "assert_macros.svh"

module rwfs_front import rwfs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  output logic       q_valid,
  output logic [5:0] q_data,
  input  logic       q_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [5:0]    slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;
  logic [5:0]    rev;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rev[5 - i] = s_tdata[i];
    end
  end

  assign s_tready = (count != FULL_CNT);
  assign push     = s_tvalid && s_tready && (s_tdata[7:6] == 2'b01);
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= rev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `RWFS_ASSERT_NEXT(a_count_track, 1'b1, (count == $past(count) + CW'($past(push)) - CW'($past(pop))), "queue fill count out of step")
  `RWFS_ASSERT(a_empty_ptrs, (count == '0) |-> (wr_ptr == rd_ptr), "empty queue with pointers apart")

endmodule

// File: rtl/core/rwfs_back.sv
// sync engine: bit hunt, word assembly, parity and frame tracking, frame store and run output
`include "assert_macros.svh"

module rwfs_back import rwfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  logic [5:0] q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_beat_t out_beat,
  input  logic      out_ready
);

  back_state_t state, state_next;

  logic [2:0]        mode;
  logic [31:0]       shift_word;
  logic [5:0]        residue;
  logic signed [5:0] fill_pos;
  logic [3:0]        wsc;
  logic [2:0]        fsc;
  logic [3:0]        pfc;
  logic [5:0]        fwc;
  logic [4:0]        held_len;
  logic [3:0]        held_seq;
  logic              err_marked;
  logic [5:0]        first_err;
  logic [5:0]        b6;
  logic [2:0]        bit_i;
  logic [5:0]        emit_idx;
  logic [5:0]        emit_cnt;
  logic              hdr_pend;
  logic [24:0]       hdr_word;

  // hunt stage
  logic [31:0]       hunt_sw;
  chk_t              hunt_chk;
  logic [5:0]        hunt_res;

  // fill stage
  logic [2:0]        fill_k;
  logic [31:0]       fill_sw;
  logic [5:0]        fill_res;
  logic signed [5:0] fill_pos_next;
  logic              fill_done;

  // word stage
  chk_t              wchk;
  logic              good;
  logic              pre;
  logic [3:0]        pfc_inc;
  logic [3:0]        wsc_inc;
  logic [2:0]        fsc_inc;
  logic              lost;
  logic [5:0]        fill;
  logic [5:0]        fwc_inc;
  logic              emit_ok;
  logic [2:0]        mode_next;
  logic [31:0]       shift_next;
  logic [3:0]        wsc_next;
  logic [2:0]        fsc_next;
  logic [3:0]        pfc_next;
  logic [5:0]        fwc_next;
  logic [4:0]        held_len_next;
  logic [3:0]        held_seq_next;
  logic              err_next;
  logic [5:0]        first_err_next;
  logic              st_we;
  logic [5:0]        st_addr;
  logic              do_emit;
  logic [5:0]        emit_cnt_next;
  logic              defer_hdr;

  // ram and output control
  logic              ram_we;
  logic [5:0]        ram_waddr;
  logic [24:0]       ram_wdata;
  logic              ram_re;
  logic [24:0]       ram_rdata;
  logic              out_load;
  logic              emit_last;

  rwfs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (emit_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    hunt_sw  = {shift_word[30:0], b6[3'd6 - bit_i]};
    hunt_chk = check_word(hunt_sw);
    hunt_res = 6'(b6 << bit_i);
  end

  always_comb begin
    fill_k    = 3'(-fill_pos);
    fill_done = (fill_pos <= 6'sd0);
    if (fill_done) begin
      fill_res      = 6'(b6 << (3'd6 - fill_k));
      fill_sw       = shift_word | {26'd0, b6 >> fill_k};
      fill_pos_next = fill_pos + 6'sd24;
    end else begin
      fill_res      = residue;
      fill_sw       = shift_word | ({26'd0, b6} << fill_pos[4:0]);
      fill_pos_next = fill_pos - 6'sd6;
    end
  end

  always_comb begin
    wchk    = check_word(shift_word);
    good    = wchk.good;
    pre     = good && is_preamble(wchk.word);
    pfc_inc = (pfc == 4'd15) ? pfc : pfc + 4'd1;
    wsc_inc = (wsc == 4'd15) ? wsc : wsc + 4'd1;
    fsc_inc = (fsc == 3'd7) ? fsc : fsc + 3'd1;
    lost    = !good && (pfc_inc >= cfg.parity_fail_limit);
    fill    = fwc - 6'd1;
    fwc_inc = fwc + 6'd1;
    emit_ok = !(err_marked && (first_err == 6'd0));

    mode_next      = mode;
    shift_next     = shift_word;
    wsc_next       = wsc;
    fsc_next       = fsc;
    pfc_next       = pfc;
    fwc_next       = fwc;
    held_len_next  = held_len;
    held_seq_next  = held_seq;
    err_next       = err_marked;
    first_err_next = first_err;
    st_we          = 1'b0;
    st_addr        = fwc;
    do_emit        = 1'b0;
    emit_cnt_next  = fwc;
    defer_hdr      = 1'b0;

    unique case (mode)
      MODE_WSYNCING: begin
        shift_next = next_word(shift_word, residue);
        if (good) begin
          wsc_next = wsc_inc;
          if (wsc_inc >= cfg.word_sync_needed) begin
            mode_next = MODE_WSYNC;
            pfc_next  = 4'd0;
            fsc_next  = 3'd1;
            if (pre) begin
              held_seq_next  = 4'd8;
              st_we          = 1'b1;
              st_addr        = 6'd0;
              fwc_next       = 6'd1;
              err_next       = 1'b0;
              first_err_next = 6'd0;
              mode_next      = MODE_FSYNCING;
            end
          end
        end else if (wsc <= 4'd1) begin
          wsc_next  = 4'd0;
          mode_next = MODE_NONE;
        end else begin
          wsc_next = wsc - 4'd1;
        end
      end
      MODE_WSYNC: begin
        pfc_next = good ? 4'd0 : pfc_inc;
        if (lost) begin
          mode_next = MODE_NONE;
        end else begin
          shift_next = next_word(shift_word, residue);
          if (pre) begin
            held_seq_next  = 4'd8;
            st_we          = 1'b1;
            st_addr        = 6'd0;
            fwc_next       = 6'd1;
            err_next       = 1'b0;
            first_err_next = 6'd0;
            mode_next      = MODE_FSYNCING;
          end
        end
      end
      MODE_FSYNCING, MODE_FULL: begin
        pfc_next = good ? 4'd0 : pfc_inc;
        if (lost) begin
          mode_next = MODE_NONE;
        end else begin
          shift_next = next_word(shift_word, residue);
          if (fill == 6'd0) begin
            // second header word
            if (!good) begin
              mode_next = MODE_WSYNC;
              fsc_next  = (cfg.frame_sync_needed != 3'd0) ? cfg.frame_sync_needed - 3'd1 : 3'd0;
            end else begin
              st_we         = 1'b1;
              fwc_next      = fwc_inc;
              held_len_next = wchk.word[13:9];
              if (held_seq[3] || ((held_seq[2:0] + 3'd1) == wchk.word[16:14])) begin
                held_seq_next = {1'b0, wchk.word[16:14]};
                if ((mode == MODE_FULL) && (wchk.word[13:9] == 5'd0) && emit_ok) begin
                  do_emit       = 1'b1;
                  emit_cnt_next = fwc_inc;
                end
              end else begin
                mode_next = MODE_WSYNC;
              end
            end
          end else if (fill > {1'b0, held_len}) begin
            // frame boundary: this word opens the next frame
            fwc_next       = 6'd1;
            err_next       = 1'b0;
            first_err_next = 6'd0;
            st_addr        = 6'd0;
            st_we          = 1'b1;
            if (mode == MODE_FSYNCING) begin
              if (!pre) begin
                mode_next = MODE_WSYNC;
              end else begin
                fsc_next = fsc_inc;
                if (fsc_inc >= cfg.frame_sync_needed) begin
                  mode_next = MODE_FULL;
                  if (emit_ok) begin
                    do_emit       = 1'b1;
                    emit_cnt_next = fwc;
                    defer_hdr     = 1'b1;
                    st_we         = 1'b0;
                  end
                end
              end
            end else if (!good) begin
              err_next = 1'b1;
            end else if (!pre) begin
              mode_next = MODE_WSYNC;
            end
          end else begin
            if (!good && !err_marked) begin
              err_next       = 1'b1;
              first_err_next = fwc;
            end
            if (fwc < 6'(STORE_DEPTH)) begin
              st_we    = 1'b1;
              fwc_next = fwc_inc;
            end
            if ((fill == {1'b0, held_len}) && (mode == MODE_FULL) && emit_ok) begin
              do_emit       = 1'b1;
              emit_cnt_next = (fwc < 6'(STORE_DEPTH)) ? fwc_inc : fwc;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_NONE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (mode == MODE_NONE) ? ST_HUNT : ST_FILL;
        end
      end
      ST_HUNT: begin
        if (hunt_chk.good || (bit_i == 3'd6)) begin
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        state_next = fill_done ? ST_WORD : ST_IDLE;
      end
      ST_WORD: begin
        state_next = do_emit ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_load) begin
          if (emit_last) begin
            state_next = hdr_pend ? ST_HDR_WR : ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_HDR_WR: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    ram_re    = (state == ST_EMIT_RD);
    out_load  = (state == ST_EMIT_OUT) && (!out_valid || out_ready);
    emit_last = (emit_idx == emit_cnt - 6'd1);
    if (state == ST_HDR_WR) begin
      ram_we    = 1'b1;
      ram_waddr = 6'd0;
      ram_wdata = hdr_word;
    end else begin
      ram_we    = (state == ST_WORD) && st_we;
      ram_waddr = st_addr;
      ram_wdata = pack_word(wchk.word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_NONE;
      shift_word <= '0;
      residue    <= '0;
      fill_pos   <= '0;
      wsc        <= '0;
      fsc        <= '0;
      pfc        <= '0;
      fwc        <= '0;
      held_len   <= '0;
      held_seq   <= '0;
      err_marked <= 1'b0;
      first_err  <= '0;
      hdr_pend   <= 1'b0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            b6    <= q_data;
            bit_i <= 3'd1;
          end
        end
        ST_HUNT: begin
          bit_i <= bit_i + 3'd1;
          if (hunt_chk.good) begin
            shift_word <= next_word(hunt_sw, hunt_res);
            residue    <= hunt_res;
            fill_pos   <= 6'sd18 + $signed({3'b000, bit_i});
            mode       <= MODE_WSYNCING;
            wsc        <= 4'd1;
          end else begin
            shift_word <= hunt_sw;
          end
        end
        ST_FILL: begin
          shift_word <= fill_sw;
          residue    <= fill_res;
          fill_pos   <= fill_pos_next;
        end
        ST_WORD: begin
          mode       <= mode_next;
          shift_word <= shift_next;
          wsc        <= wsc_next;
          fsc        <= fsc_next;
          pfc        <= pfc_next;
          fwc        <= fwc_next;
          held_len   <= held_len_next;
          held_seq   <= held_seq_next;
          err_marked <= err_next;
          first_err  <= first_err_next;
          if (do_emit) begin
            emit_cnt <= emit_cnt_next;
            emit_idx <= 6'd0;
            hdr_pend <= defer_hdr;
            hdr_word <= pack_word(wchk.word);
          end
        end
        ST_EMIT_OUT: begin
          if (out_load) begin
            emit_idx <= emit_idx + 6'd1;
          end
        end
        ST_HDR_WR: begin
          hdr_pend <= 1'b0;
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat.word_data       <= ram_rdata[23:0];
      out_beat.word_good       <= ram_rdata[24];
      out_beat.word_index      <= emit_idx;
      out_beat.frame_length    <= held_len;
      out_beat.sequence_number <= held_seq[2:0];
      out_beat.sync_state      <= mode;
      out_beat.last            <= emit_last;
    end
  end

  `RWFS_ASSERT(a_out_full_sync, out_valid |-> (out_beat.sync_state == MODE_FULL), "result beat sent outside full sync")
  `RWFS_ASSERT(a_no_store_during_run, ((state == ST_EMIT_RD) || (state == ST_EMIT_OUT)) |-> !ram_we, "frame store written during a run")
  `RWFS_ASSERT(a_run_index, (state == ST_EMIT_OUT) |-> (emit_idx < emit_cnt), "run index beyond frame word count")

endmodule
